// ===== design/fnls_pkg.sv =====
// ----------------------------------------------------------------------------
// fnls_pkg
// Shared types and constants for the facet normal Lambert shader.
// ----------------------------------------------------------------------------
package fnls_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int LIGHT_W         = 16;
    localparam int GREY_W          = 8;
    localparam int SLOPE_W         = 32;
    localparam int USER_W          = 2;
    localparam int CFG_IDX_W       = 2;
    localparam int OUT_W           = ((GREY_W + 2 * SLOPE_W + 7) / 8) * 8;

    // pipeline depth of the grey level path and of the slope divider
    localparam int GREY_LAT = 16;
    localparam int DIV_LAT  = SLOPE_W + 1;

    // tuser bit positions on the result side
    localparam int USR_VERT  = 0;
    localparam int USR_DEGEN = 1;

    localparam logic signed [LIGHT_W-1:0] LIGHT_Z_RST   = 16'sh4000;
    localparam logic [SLOPE_W-1:0]        SLOPE_POS_SAT = 32'h7FFF_FFFF;
    localparam logic [SLOPE_W-1:0]        SLOPE_NEG_SAT = 32'h8000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LIGHT_X = 2'd0,
        CFG_LIGHT_Y = 2'd1,
        CFG_LIGHT_Z = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic degen;
        logic vert;
        logic cx_neg;
        logic cx_zero;
        logic cy_neg;
        logic cy_zero;
        logic cz_neg;
    } t_flags;

endpackage

// ===== design/fnls_slope_div.sv =====
// ----------------------------------------------------------------------------
// fnls_slope_div
// Pipelined restoring divider: (num * 2^16) / den, one quotient bit per stage.
// ----------------------------------------------------------------------------
module fnls_slope_div #(
    parameter int MAG_W = 67
) (
    input  logic                         i_clk,
    input  logic                         i_ce,
    input  logic [MAG_W-1:0]             i_num,
    input  logic [MAG_W-1:0]             i_den,
    output logic [fnls_pkg::SLOPE_W-1:0] o_quo,
    output logic                         o_ovf
);

    localparam int QW  = fnls_pkg::SLOPE_W;
    localparam int NW  = MAG_W + 16;
    localparam int XW  = MAG_W + QW;

    logic [NW-1:0]    r_rem [QW+1];
    logic [MAG_W-1:0] r_den [QW+1];
    logic [QW-1:0]    r_quo [QW+1];
    logic             r_ovf [QW+1];

    // quotient of 2^32 or more saturates whatever the sign
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_rem[0] <= {i_num, 16'b0};
            r_den[0] <= i_den;
            r_quo[0] <= '0;
            r_ovf[0] <= ({16'b0, i_num} >= {i_den, 16'b0});
        end
    end

    for (genvar k = 1; k <= QW; k++) begin : g_step
        logic [XW-1:0] w_rem;
        logic [XW-1:0] w_dsh;
        logic          w_ge;
        logic [NW-1:0] n_rem;
        logic [QW-1:0] n_quo;

        always_comb begin
            w_rem = XW'(r_rem[k-1]);
            w_dsh = XW'(r_den[k-1]) << (QW - k);
            w_ge  = (w_rem >= w_dsh);
            n_rem = r_rem[k-1];
            n_quo = r_quo[k-1];
            if (w_ge) begin
                n_rem          = NW'(w_rem - w_dsh);
                n_quo[QW - k]  = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_rem[k] <= n_rem;
                r_den[k] <= r_den[k-1];
                r_quo[k] <= n_quo;
                r_ovf[k] <= r_ovf[k-1];
            end
        end
    end

    assign o_quo = r_quo[QW];
    assign o_ovf = r_ovf[QW];

endmodule

// ===== design/fnls_grey.sv =====
// ----------------------------------------------------------------------------
// fnls_grey
// Grey level path: normalise the normal, dot with light, bitwise level search.
// ----------------------------------------------------------------------------
module fnls_grey #(
    parameter int MAG_W = 67
) (
    input  logic                                    i_clk,
    input  logic                                    i_ce,
    input  logic [2:0][MAG_W-1:0]                   i_mag,
    input  logic [2:0]                              i_neg,
    input  logic [2:0][fnls_pkg::LIGHT_W-1:0]       i_light,
    output logic [fnls_pkg::GREY_W-1:0]             o_grey
);

    localparam int NG  = (MAG_W + 7) / 8;
    localparam int PW8 = NG * 8;
    localparam int GW  = $clog2(NG);
    localparam int SHW = $clog2(PW8 + 1);
    localparam int RW  = 116;
    localparam int SRCH = fnls_pkg::GREY_W;

    // G1: group flags
    logic [2:0][MAG_W-1:0] r1_mag;
    logic [2:0]            r1_neg;
    logic [PW8-1:0]        r1_or;
    logic [NG-1:0]         r1_grp;
    logic [PW8-1:0]        n1_or;
    logic [NG-1:0]         n1_grp;

    always_comb begin
        n1_or = PW8'(i_mag[0] | i_mag[1] | i_mag[2]);
        for (int g = 0; g < NG; g++) begin
            n1_grp[g] = |n1_or[g*8 +: 8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r1_mag <= i_mag;
            r1_neg <= i_neg;
            r1_or  <= n1_or;
            r1_grp <= n1_grp;
        end
    end

    // G2: common shift that brings every magnitude below 2^31
    logic [2:0][MAG_W-1:0] r2_mag;
    logic [2:0]            r2_neg;
    logic [SHW-1:0]        r2_sh;
    logic [GW-1:0]         w2_hg;
    logic [7:0]            w2_byte;
    logic [SHW-1:0]        w2_len;
    logic [SHW-1:0]        n2_sh;

    always_comb begin
        w2_hg = '0;
        for (int g = 0; g < NG; g++) begin
            if (r1_grp[g]) w2_hg = GW'(g);
        end
        w2_byte = r1_or[{w2_hg, 3'b000} +: 8];
        w2_len  = '0;
        for (int b = 0; b < 8; b++) begin
            if (w2_byte[b]) w2_len = SHW'({w2_hg, 3'b000}) + SHW'(b + 1);
        end
        n2_sh = (w2_len > SHW'(31)) ? w2_len - SHW'(31) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r2_mag <= r1_mag;
            r2_neg <= r1_neg;
            r2_sh  <= n2_sh;
        end
    end

    // G3: reduced components
    logic [30:0]        r3_mm [3];
    logic signed [31:0] r3_r  [3];

    for (genvar i = 0; i < 3; i++) begin : g_red
        logic [MAG_W-1:0] w_shf;
        logic [30:0]      w_mm;

        always_comb begin
            w_shf = r2_mag[i] >> r2_sh;
            w_mm  = w_shf[30:0];
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r3_mm[i] <= w_mm;
                r3_r[i]  <= r2_neg[i] ? -$signed({1'b0, w_mm}) : $signed({1'b0, w_mm});
            end
        end
    end

    // G4: light products and squares
    logic signed [47:0] r4_lp [3];
    logic [61:0]        r4_sq [3];

    for (genvar i = 0; i < 3; i++) begin : g_prod
        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r4_lp[i] <= 48'($signed(i_light[i])) * 48'(r3_r[i]);
                r4_sq[i] <= 62'(r3_mm[i]) * 62'(r3_mm[i]);
            end
        end
    end

    // G5: dot product and squared length
    logic signed [49:0] r5_d;
    logic [63:0]        r5_s;

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r5_d <= 50'(r4_lp[0]) + 50'(r4_lp[1]) + 50'(r4_lp[2]);
            r5_s <= 64'(r4_sq[0]) + 64'(r4_sq[1]) + 64'(r4_sq[2]);
        end
    end

    // G6: 255 * |d|
    logic [57:0] r6_a;
    logic [63:0] r6_s;
    logic [49:0] w6_ad;

    always_comb begin
        w6_ad = r5_d[49] ? 50'(-r5_d) : 50'(r5_d);
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r6_a <= (58'(w6_ad) << 8) - 58'(w6_ad);
            r6_s <= r5_s;
        end
    end

    // G7: partial products of the square
    logic [57:0] r7_ll;
    logic [57:0] r7_lh;
    logic [57:0] r7_hh;
    logic [63:0] r7_s;

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r7_ll <= 58'(r6_a[28:0]) * 58'(r6_a[28:0]);
            r7_lh <= 58'(r6_a[28:0]) * 58'(r6_a[57:29]);
            r7_hh <= 58'(r6_a[57:29]) * 58'(r6_a[57:29]);
            r7_s  <= r6_s;
        end
    end

    // G8 and search: compare s * g^2 * 2^28 against (255 * d)^2
    logic [RW-1:0] r_rhs [SRCH+1];
    logic [63:0]   r_s   [SRCH+1];
    logic [7:0]    r_g   [SRCH+1];
    logic [15:0]   r_gsq [SRCH+1];

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_rhs[0] <= (RW'(r7_hh) << 58) + (RW'(r7_lh) << 30) + RW'(r7_ll);
            r_s[0]   <= r7_s;
            r_g[0]   <= '0;
            r_gsq[0] <= '0;
        end
    end

    for (genvar j = 0; j < SRCH; j++) begin : g_srch
        localparam int K = SRCH - 1 - j;
        logic [7:0]    w_t;
        logic [15:0]   w_tsq;
        logic [79:0]   w_prd;
        logic [RW-1:0] w_lhs;
        logic          w_take;

        always_comb begin
            w_t    = r_g[j] | 8'(1 << K);
            // (g + 2^K)^2 with g holding only higher bits
            w_tsq  = r_gsq[j] + (16'(r_g[j]) << (K + 1)) + 16'(1 << (2 * K));
            w_prd  = 80'(r_s[j]) * 80'(w_tsq);
            w_lhs  = RW'(w_prd) << 28;
            w_take = (w_lhs <= r_rhs[j]);
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_rhs[j+1] <= r_rhs[j];
                r_s[j+1]   <= r_s[j];
                r_g[j+1]   <= w_take ? w_t : r_g[j];
                r_gsq[j+1] <= w_take ? w_tsq : r_gsq[j];
            end
        end
    end

    assign o_grey = r_g[SRCH];

endmodule

// ===== design/facet_normal_lambert_shader_unit.sv =====
// ----------------------------------------------------------------------------
// facet_normal_lambert_shader_unit
// Facet normal by cross product, Lambert grey level and height slopes.
// ----------------------------------------------------------------------------
// The delay from input request to result is set by the 32-stage slope divider.
// Throughput: one facet per cycle; a stalled result freezes the whole pipeline.
// Reset (synchronous, active low) clears all valid bits and sets the light
// direction to (0, 0, 1.0).
// ----------------------------------------------------------------------------
module facet_normal_lambert_shader_unit #(
    parameter int COORD_WIDTH = fnls_pkg::COORD_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // first_x, first_y, first_z, middle_x, middle_y, middle_z, third_x, third_y, third_z
    input  logic [((9*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // grey_level, slope_x, slope_y
    output logic [fnls_pkg::OUT_W-1:0]         m_axis_tdata,
    // vertical_facet, degenerate_facet
    output logic [fnls_pkg::USER_W-1:0]        m_axis_tuser,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [fnls_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [fnls_pkg::LIGHT_W-1:0]       i_cfg_data
);

    localparam int CW   = COORD_WIDTH;
    localparam int EW   = CW + 1;
    localparam int KL   = EW / 2;
    localparam int KH   = EW - KL;
    localparam int PW   = 2 * EW;
    localparam int CPW  = PW + 1;
    localparam int QW   = fnls_pkg::SLOPE_W;
    localparam int GDLY = fnls_pkg::DIV_LAT - fnls_pkg::GREY_LAT;
    localparam int LAT  = 5 + fnls_pkg::DIV_LAT + 1;

    localparam int A_SEL [6] = '{1, 2, 2, 0, 0, 1};
    localparam int B_SEL [6] = '{2, 1, 0, 2, 1, 0};

    // ---------------- configuration ----------------
    logic [2:0][fnls_pkg::LIGHT_W-1:0] r_light;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_light[0] <= '0;
            r_light[1] <= '0;
            r_light[2] <= fnls_pkg::LIGHT_Z_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                fnls_pkg::CFG_LIGHT_X: r_light[0] <= i_cfg_data;
                fnls_pkg::CFG_LIGHT_Y: r_light[1] <= i_cfg_data;
                fnls_pkg::CFG_LIGHT_Z: r_light[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- flow control ----------------
    logic [LAT:1] r_vld;
    logic         w_ce;

    assign w_ce          = !r_vld[LAT] || m_axis_tready;
    assign s_axis_tready = w_ce;
    assign m_axis_tvalid = r_vld[LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_ce) begin
            r_vld <= {r_vld[LAT-1:1], s_axis_tvalid};
        end
    end

    // ---------------- S1: edges ----------------
    logic signed [EW-1:0] r1_e1 [3];
    logic signed [EW-1:0] r1_e2 [3];

    for (genvar i = 0; i < 3; i++) begin : g_edge
        logic signed [CW-1:0] w_f, w_m, w_t;

        always_comb begin
            w_f = $signed(s_axis_tdata[i*CW +: CW]);
            w_m = $signed(s_axis_tdata[(3+i)*CW +: CW]);
            w_t = $signed(s_axis_tdata[(6+i)*CW +: CW]);
        end

        always_ff @(posedge i_clk) begin
            if (w_ce) begin
                r1_e1[i] <= EW'(w_f) - EW'(w_m);
                r1_e2[i] <= EW'(w_t) - EW'(w_m);
            end
        end
    end

    // ---------------- S2/S3: split products ----------------
    logic signed [EW+KL:0]   r2_pl [6];
    logic signed [EW+KH-1:0] r2_ph [6];
    logic signed [PW-1:0]    r3_p  [6];

    for (genvar p = 0; p < 6; p++) begin : g_mul
        logic signed [EW-1:0] w_a, w_b;

        always_comb begin
            w_a = r1_e1[A_SEL[p]];
            w_b = r1_e2[B_SEL[p]];
        end

        always_ff @(posedge i_clk) begin
            if (w_ce) begin
                r2_pl[p] <= (EW+KL+1)'(w_a) * (EW+KL+1)'($signed({1'b0, w_b[KL-1:0]}));
                r2_ph[p] <= (EW+KH)'(w_a) * (EW+KH)'($signed(w_b[EW-1:KL]));
                r3_p[p]  <= (PW'(r2_ph[p]) <<< KL) + PW'(r2_pl[p]);
            end
        end
    end

    // ---------------- S4: cross product ----------------
    logic signed [CPW-1:0] r4_c [3];

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r4_c[0] <= CPW'(r3_p[0]) - CPW'(r3_p[1]);
            r4_c[1] <= CPW'(r3_p[2]) - CPW'(r3_p[3]);
            r4_c[2] <= CPW'(r3_p[4]) - CPW'(r3_p[5]);
        end
    end

    // ---------------- S5: magnitudes and flags ----------------
    logic [2:0][CPW-1:0] r5_mag;
    logic [2:0]          r5_neg;
    fnls_pkg::t_flags    r5_flags;
    fnls_pkg::t_flags    n5_flags;
    logic [2:0]          w5_zero;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w5_zero[i] = (r4_c[i] == '0);
        end
        n5_flags.degen   = &w5_zero;
        n5_flags.vert    = w5_zero[2] && !(&w5_zero);
        n5_flags.cx_neg  = r4_c[0][CPW-1];
        n5_flags.cx_zero = w5_zero[0];
        n5_flags.cy_neg  = r4_c[1][CPW-1];
        n5_flags.cy_zero = w5_zero[1];
        n5_flags.cz_neg  = r4_c[2][CPW-1];
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            for (int i = 0; i < 3; i++) begin
                r5_mag[i] <= r4_c[i][CPW-1] ? CPW'(-r4_c[i]) : CPW'(r4_c[i]);
                r5_neg[i] <= r4_c[i][CPW-1];
            end
            r5_flags <= n5_flags;
        end
    end

    // ---------------- slope dividers and grey path ----------------
    logic [QW-1:0]                 w_qx, w_qy;
    logic                          w_ovx, w_ovy;
    logic [fnls_pkg::GREY_W-1:0]   w_grey;

    fnls_slope_div #(.MAG_W(CPW)) u_div_x (
        .i_clk (i_clk),
        .i_ce  (w_ce),
        .i_num (r5_mag[0]),
        .i_den (r5_mag[2]),
        .o_quo (w_qx),
        .o_ovf (w_ovx)
    );

    fnls_slope_div #(.MAG_W(CPW)) u_div_y (
        .i_clk (i_clk),
        .i_ce  (w_ce),
        .i_num (r5_mag[1]),
        .i_den (r5_mag[2]),
        .o_quo (w_qy),
        .o_ovf (w_ovy)
    );

    fnls_grey #(.MAG_W(CPW)) u_grey (
        .i_clk   (i_clk),
        .i_ce    (w_ce),
        .i_mag   (r5_mag),
        .i_neg   (r5_neg),
        .i_light (r_light),
        .o_grey  (w_grey)
    );

    // hold grey level and flags level with the divider output
    logic [fnls_pkg::GREY_W-1:0] r_gdly [GDLY];
    fnls_pkg::t_flags            r_fdly [fnls_pkg::DIV_LAT];

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_gdly[0] <= w_grey;
            for (int k = 1; k < GDLY; k++) r_gdly[k] <= r_gdly[k-1];
            r_fdly[0] <= r5_flags;
            for (int k = 1; k < fnls_pkg::DIV_LAT; k++) r_fdly[k] <= r_fdly[k-1];
        end
    end

    // ---------------- output stage ----------------
    function automatic logic [QW-1:0] f_slope(
        input logic [QW-1:0] quo,
        input logic          ovf,
        input logic          n_neg,
        input logic          n_zero,
        input logic          d_neg
    );
        logic [QW-1:0] res;
        if (n_zero) begin
            res = '0;
        end else if (n_neg == d_neg) begin
            res = (ovf || (quo > fnls_pkg::SLOPE_NEG_SAT)) ? fnls_pkg::SLOPE_NEG_SAT : -quo;
        end else begin
            res = (ovf || quo[QW-1]) ? fnls_pkg::SLOPE_POS_SAT : quo;
        end
        return res;
    endfunction

    function automatic logic [QW-1:0] f_vslope(input logic n_neg, input logic n_zero);
        logic [QW-1:0] res;
        if (n_zero)     res = '0;
        else if (n_neg) res = fnls_pkg::SLOPE_POS_SAT;
        else            res = fnls_pkg::SLOPE_NEG_SAT;
        return res;
    endfunction

    fnls_pkg::t_flags              w_fl;
    logic [fnls_pkg::GREY_W-1:0]   n_grey;
    logic [QW-1:0]                 n_sx, n_sy;
    logic [fnls_pkg::OUT_W-1:0]    r_out;
    logic [fnls_pkg::USER_W-1:0]   r_user;

    always_comb begin
        w_fl   = r_fdly[fnls_pkg::DIV_LAT-1];
        n_grey = r_gdly[GDLY-1];
        n_sx   = f_slope(w_qx, w_ovx, w_fl.cx_neg, w_fl.cx_zero, w_fl.cz_neg);
        n_sy   = f_slope(w_qy, w_ovy, w_fl.cy_neg, w_fl.cy_zero, w_fl.cz_neg);
        if (w_fl.degen) begin
            n_grey = '0;
            n_sx   = '0;
            n_sy   = '0;
        end else if (w_fl.vert) begin
            n_sx = f_vslope(w_fl.cx_neg, w_fl.cx_zero);
            n_sy = f_vslope(w_fl.cy_neg, w_fl.cy_zero);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_out  <= fnls_pkg::OUT_W'({n_sy, n_sx, n_grey});
            r_user <= {w_fl.degen, w_fl.vert};
        end
    end

    assign m_axis_tdata = r_out;
    assign m_axis_tuser = r_user;

endmodule

// ===== design/fnls_checker.sv =====
// ----------------------------------------------------------------------------
// fnls_checker
// Port-level checks on the facet shader result stream.
// ----------------------------------------------------------------------------
module fnls_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [fnls_pkg::OUT_W-1:0]    m_axis_tdata,
    input logic [fnls_pkg::USER_W-1:0]   m_axis_tuser
);

    logic [31:0] w_sx, w_sy;

    assign w_sx = m_axis_tdata[39:8];
    assign w_sy = m_axis_tdata[71:40];

    // hold a stalled request
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result request dropped under stall");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed under stall");

    // an empty output register never blocks input
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output");

    a_degen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[fnls_pkg::USR_DEGEN] |->
            m_axis_tdata == '0 && !m_axis_tuser[fnls_pkg::USR_VERT])
        else $error("degenerate facet with non-zero result");

    a_vert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[fnls_pkg::USR_VERT] |->
            (w_sx == 32'h0 || w_sx == 32'h7FFF_FFFF || w_sx == 32'h8000_0000) &&
            (w_sy == 32'h0 || w_sy == 32'h7FFF_FFFF || w_sy == 32'h8000_0000))
        else $error("vertical facet slope not saturated");

endmodule

bind facet_normal_lambert_shader_unit fnls_checker u_fnls_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
